// ===== design/s5udp_pkg.sv =====
// Shared types, codes and constants for the SOCKS5 UDP header parser.
`default_nettype none
package s5udp_pkg;

  // Saturation value of the datagram byte counter.
  localparam logic [8:0] COUNT_MAX = 9'd511;

  // Address type codes as they appear in the ATYP byte.
  localparam logic [7:0] ATYP_IPV4   = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN = 8'd3;
  localparam logic [7:0] ATYP_IPV6   = 8'd4;

  // Fixed address lengths.
  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  // Byte classes on the result channel.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_ADDR    = 2'd1;
  localparam logic [1:0] KIND_PORT    = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD = 2'd3;

  // Decoded address kinds.
  localparam logic [1:0] ADDR_UNKNOWN = 2'd0;
  localparam logic [1:0] ADDR_IPV4    = 2'd1;
  localparam logic [1:0] ADDR_DOMAIN  = 2'd2;
  localparam logic [1:0] ADDR_IPV6    = 2'd3;

  // Final status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_FRAG      = 2'd2;
  localparam logic [1:0] STATUS_BAD_ATYP  = 2'd3;

  // Parser phases, one per header field, plus the payload phase.
  typedef enum logic [2:0] {
    PH_RSV  = 3'd0,
    PH_FRAG = 3'd1,
    PH_ATYP = 3'd2,
    PH_DLEN = 3'd3,
    PH_ADDR = 3'd4,
    PH_PHI  = 3'd5,
    PH_PLO  = 3'd6,
    PH_DATA = 3'd7
  } phase_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [8:0] byte_count;
    phase_t     phase;
    logic       frag_nonzero;
    logic [1:0] addr_kind;
    logic       bad_type;
    logic [7:0] field_remaining;
    logic [7:0] addr_position;
    logic [7:0] port_high;
    logic [7:0] port_low;
    logic       port_done;
  } state_t;

  // Result fields produced for one byte.
  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [7:0]  byte_value;
    logic [1:0]  address_kind;
    logic [7:0]  address_index;
    logic [15:0] port_number;
    logic        port_ready;
    logic        is_last;
    logic [1:0]  status;
  } result_t;

  localparam state_t ST_RESET = '{
    byte_count:      9'd0,
    phase:           PH_RSV,
    frag_nonzero:    1'b0,
    addr_kind:       ADDR_UNKNOWN,
    bad_type:        1'b0,
    field_remaining: 8'd0,
    addr_position:   8'd0,
    port_high:       8'd0,
    port_low:        8'd0,
    port_done:       1'b0
  };

endpackage
`default_nettype wire

// ===== design/s5udp_step.sv =====
// Combinational per-byte step of the parser: next state and result for one byte.
`default_nettype none
module s5udp_step (
  input  wire s5udp_pkg::state_t  st,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_datagram,
  output s5udp_pkg::state_t       st_next,
  output s5udp_pkg::result_t      res
);
  import s5udp_pkg::*;

  state_t upd;

  // Next state: advance through the header fields, then clear on the last byte.
  always_comb begin
    upd = st;
    if (st.byte_count != COUNT_MAX) begin
      upd.byte_count = st.byte_count + 9'd1;
    end
    case (st.phase)
      PH_RSV: begin
        if (st.byte_count != 9'd0) begin
          upd.phase = PH_FRAG;
        end
      end
      PH_FRAG: begin
        upd.frag_nonzero = (data_byte != 8'd0);
        upd.phase        = PH_ATYP;
      end
      PH_ATYP: begin
        if (data_byte == ATYP_IPV4) begin
          upd.addr_kind       = ADDR_IPV4;
          upd.field_remaining = IPV4_LEN;
          upd.phase           = PH_ADDR;
        end else if (data_byte == ATYP_DOMAIN) begin
          upd.addr_kind = ADDR_DOMAIN;
          upd.phase     = PH_DLEN;
        end else if (data_byte == ATYP_IPV6) begin
          upd.addr_kind       = ADDR_IPV6;
          upd.field_remaining = IPV6_LEN;
          upd.phase           = PH_ADDR;
        end else begin
          upd.bad_type = 1'b1;
          upd.phase    = PH_DATA;
        end
      end
      PH_DLEN: begin
        upd.field_remaining = data_byte;
        upd.phase           = (data_byte != 8'd0) ? PH_ADDR : PH_PHI;
      end
      PH_ADDR: begin
        upd.addr_position   = st.addr_position + 8'd1;
        upd.field_remaining = st.field_remaining - 8'd1;
        if (st.field_remaining == 8'd1) begin
          upd.phase = PH_PHI;
        end
      end
      PH_PHI: begin
        upd.port_high = data_byte;
        upd.phase     = PH_PLO;
      end
      PH_PLO: begin
        upd.port_low  = data_byte;
        upd.port_done = 1'b1;
        upd.phase     = PH_DATA;
      end
      default: begin
        upd.phase = PH_DATA;
      end
    endcase
    st_next = end_of_datagram ? ST_RESET : upd;
  end

  // Result: classify the byte and report status on the last byte.
  always_comb begin
    res               = '0;
    res.byte_value    = data_byte;
    res.address_kind  = upd.addr_kind;
    res.port_ready    = upd.port_done;
    res.is_last       = end_of_datagram;
    if (upd.port_done) begin
      res.port_number = {upd.port_high, upd.port_low};
    end
    case (st.phase)
      PH_ADDR: begin
        res.byte_kind     = KIND_ADDR;
        res.address_index = st.addr_position;
      end
      PH_PHI, PH_PLO: begin
        res.byte_kind = KIND_PORT;
      end
      PH_DATA: begin
        res.byte_kind = st.bad_type ? KIND_HEADER : KIND_PAYLOAD;
      end
      default: begin
        res.byte_kind = KIND_HEADER;
      end
    endcase
    if (end_of_datagram) begin
      if (st.byte_count < 9'd3) begin
        res.status = STATUS_SHORT;
      end else if (upd.frag_nonzero) begin
        res.status = STATUS_FRAG;
      end else if (upd.bad_type) begin
        res.status = STATUS_BAD_ATYP;
      end else if (!upd.port_done) begin
        res.status = STATUS_SHORT;
      end else begin
        res.status = STATUS_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/socks5_udp_header_parser_unit.sv =====
// Top level of the SOCKS5 UDP request header parser.
//
// The input channel carries one datagram byte per transaction, with
// end_of_datagram set on the final byte. The output channel carries exactly
// one result per input byte: the byte's class, the byte itself, the decoded
// address kind and index, the destination port once both port bytes are in,
// and on the final byte a status (ok, too short, fragmented, bad address type).
// A byte accepted in one cycle shows its result at the output from the next
// cycle on. Throughput is one byte per cycle while the receiver does not
// stall; the parser state is updated once per byte, and one output register
// sits between the two channels. in_ready is high whenever the output register
// is empty or is being emptied in the same cycle, so a stalled receiver holds
// the result in place and blocks new input only while it stalls. Reset clears
// the parser state and the output valid flag. After each final byte the state
// returns to its reset value, ready for the next datagram.
`default_nettype none
module socks5_udp_header_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_datagram,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       byte_kind,
  output logic [7:0]       byte_value,
  output logic [1:0]       address_kind,
  output logic [7:0]       address_index,
  output logic [15:0]      port_number,
  output logic             port_ready,
  output logic             is_last,
  output logic [1:0]       status
);
  import s5udp_pkg::*;

  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;
  logic    in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Per-byte parser step.
  s5udp_step u_step (
    .st              (st),
    .data_byte       (data_byte),
    .end_of_datagram (end_of_datagram),
    .st_next         (st_next),
    .res             (res_next)
  );

  // Parser state advances on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign byte_kind     = res.byte_kind;
  assign byte_value    = res.byte_value;
  assign address_kind  = res.address_kind;
  assign address_index = res.address_index;
  assign port_number   = res.port_number;
  assign port_ready    = res.port_ready;
  assign is_last       = res.is_last;
  assign status        = res.status;

  // A final byte always leaves the parser in its reset state.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_datagram |=> st == ST_RESET)
    else $error("parser state not cleared after final byte");

  // Status is only reported on the final byte of a datagram.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> status == STATUS_OK)
    else $error("status reported on a non-final byte");

  // Address bytes only appear once the address kind is decoded.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_ADDR |-> address_kind != ADDR_UNKNOWN)
    else $error("address byte with unknown address kind");

  // The port number stays zero until both port bytes are in.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !port_ready |-> port_number == 16'd0)
    else $error("port number shown before it is complete");

endmodule
`default_nettype wire

// ===== dv/tb_socks5_udp_header_parser_unit.sv =====
// Testbench for the SOCKS5 UDP header parser: directed, long and random datagrams.
`default_nettype none
module tb_socks5_udp_header_parser_unit;
  import s5udp_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_datagram = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  byte_kind;
  logic [7:0]  byte_value;
  logic [1:0]  address_kind;
  logic [7:0]  address_index;
  logic [15:0] port_number;
  logic        port_ready;
  logic        is_last;
  logic [1:0]  status;

  // Parser state as predicted by the testbench, and the results it owes.
  state_t  hdr_state = ST_RESET;
  result_t classified_q[$];
  int      error_count = 0;
  int      bytes_sent = 0;
  int      next_gap = 0;
  int      stall_left = 0;
  bit      no_idle = 1'b0;

  socks5_udp_header_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .end_of_datagram(end_of_datagram),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_kind(byte_kind),
    .byte_value(byte_value),
    .address_kind(address_kind),
    .address_index(address_index),
    .port_number(port_number),
    .port_ready(port_ready),
    .is_last(is_last),
    .status(status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Length of a nonzero idle stretch: mostly short, now and then long.
  function automatic int stall_length();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int idle_gap();
    if (no_idle || $urandom_range(0, 99) < 65) return 0;
    return stall_length();
  endfunction

  // Predict the result for one byte and advance the parser state.
  function automatic result_t classify_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic [9:0] total;
    r = '0;
    r.byte_value = b;
    total = {1'b0, hdr_state.byte_count} + 10'd1;
    case (hdr_state.phase)
      PH_RSV: begin
        if (hdr_state.byte_count >= 9'd1) hdr_state.phase = PH_FRAG;
      end
      PH_FRAG: begin
        hdr_state.frag_nonzero = (b != 8'd0);
        hdr_state.phase = PH_ATYP;
      end
      PH_ATYP: begin
        if (b == ATYP_IPV4) begin
          hdr_state.addr_kind = ADDR_IPV4;
          hdr_state.field_remaining = IPV4_LEN;
          hdr_state.phase = PH_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          hdr_state.addr_kind = ADDR_DOMAIN;
          hdr_state.phase = PH_DLEN;
        end else if (b == ATYP_IPV6) begin
          hdr_state.addr_kind = ADDR_IPV6;
          hdr_state.field_remaining = IPV6_LEN;
          hdr_state.phase = PH_ADDR;
        end else begin
          hdr_state.bad_type = 1'b1;
          hdr_state.phase = PH_DATA;
        end
      end
      PH_DLEN: begin
        hdr_state.field_remaining = b;
        hdr_state.phase = (b != 8'd0) ? PH_ADDR : PH_PHI;
      end
      PH_ADDR: begin
        r.byte_kind = KIND_ADDR;
        r.address_index = hdr_state.addr_position;
        hdr_state.addr_position = hdr_state.addr_position + 8'd1;
        hdr_state.field_remaining = hdr_state.field_remaining - 8'd1;
        if (hdr_state.field_remaining == 8'd0) hdr_state.phase = PH_PHI;
      end
      PH_PHI: begin
        r.byte_kind = KIND_PORT;
        hdr_state.port_high = b;
        hdr_state.phase = PH_PLO;
      end
      PH_PLO: begin
        r.byte_kind = KIND_PORT;
        hdr_state.port_low = b;
        hdr_state.port_done = 1'b1;
        hdr_state.phase = PH_DATA;
      end
      default: begin
        r.byte_kind = hdr_state.bad_type ? KIND_HEADER : KIND_PAYLOAD;
      end
    endcase
    hdr_state.byte_count = (total > {1'b0, COUNT_MAX}) ? COUNT_MAX : total[8:0];
    r.address_kind = hdr_state.addr_kind;
    r.port_ready = hdr_state.port_done;
    if (hdr_state.port_done) r.port_number = {hdr_state.port_high, hdr_state.port_low};
    r.is_last = last;
    r.status = STATUS_OK;
    if (last) begin
      // Errors are reported in a fixed order of precedence.
      if (total < 10'd4) r.status = STATUS_SHORT;
      else if (hdr_state.frag_nonzero) r.status = STATUS_FRAG;
      else if (hdr_state.bad_type) r.status = STATUS_BAD_ATYP;
      else if (!hdr_state.port_done) r.status = STATUS_SHORT;
      hdr_state = ST_RESET;
    end
    return r;
  endfunction

  // Drive one byte, wait for its transaction and record the expected result.
  task automatic send_byte(input logic [7:0] b, input logic last);
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_datagram <= last;
    do @(posedge clk); while (!in_ready);
    classified_q = {classified_q, classify_byte(b, last)};
    bytes_sent++;
    // Valid drops only when the next byte is held back.
    next_gap = idle_gap();
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic send_datagram(input octet_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_drained();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
    while (classified_q.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls on the result channel.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 30) begin
      stall_left = stall_length() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare every result transaction with the oldest expected result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (classified_q.size() == 0) begin
        $display("%0t: result with no byte outstanding, expected none, actual byte %0h",
                 $time, byte_value);
        error_count++;
      end else begin
        want = classified_q.pop_front();
        check_field("byte_kind", 16'(want.byte_kind), 16'(byte_kind));
        check_field("byte_value", 16'(want.byte_value), 16'(byte_value));
        check_field("address_kind", 16'(want.address_kind), 16'(address_kind));
        check_field("address_index", 16'(want.address_index), 16'(address_index));
        check_field("port_number", want.port_number, port_number);
        check_field("port_ready", 16'(want.port_ready), 16'(port_ready));
        check_field("is_last", 16'(want.is_last), 16'(is_last));
        check_field("status", 16'(want.status), 16'(status));
      end
    end
  end

  // Short datagrams that hit each status and the corner cases of the header.
  task automatic test_directed();
    send_datagram('{8'hFF});
    send_datagram('{8'h00, 8'h00, 8'h05});
    send_datagram('{8'h00, 8'h00, 8'h00, 8'h02, 8'hAA});
    send_datagram('{8'h00, 8'h00, 8'h80, ATYP_IPV4, 8'hC0, 8'hA8, 8'h00, 8'h01,
                    8'hFF, 8'hFF, 8'h55});
    send_datagram('{8'hFF, 8'hFF, 8'h00, ATYP_DOMAIN, 8'h00, 8'h00, 8'h00});
  endtask

  // One datagram long enough to saturate the byte counter, sent back to back.
  task automatic test_long_datagram();
    octet_q_t d;
    d = '{8'h00, 8'h00, 8'h00, ATYP_IPV4, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h90};
    repeat (520) d = {d, 8'($urandom)};
    no_idle = 1'b1;
    send_datagram(d);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed datagram with random content, sometimes cut short.
  function automatic octet_q_t build_datagram();
    octet_q_t   d;
    int         pick;
    int         alen;
    int         cut;
    logic [7:0] b;
    alen = 0;
    d = {d, 8'($urandom)};
    d = {d, 8'($urandom)};
    d = {d, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00};
    pick = $urandom_range(0, 19);
    if (pick <= 5) begin
      d = {d, ATYP_IPV4};
      alen = int'(IPV4_LEN);
    end else if (pick <= 11) begin
      d = {d, ATYP_IPV6};
      alen = int'(IPV6_LEN);
    end else if (pick <= 18) begin
      d = {d, ATYP_DOMAIN};
      case ($urandom_range(0, 29))
        0: alen = 0;
        1: alen = 255;
        default: alen = $urandom_range(1, 24);
      endcase
      d = {d, 8'(alen)};
    end else begin
      do b = 8'($urandom); while (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6);
      d = {d, b};
    end
    repeat (alen + 2 + $urandom_range(0, 12)) d = {d, 8'($urandom)};
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, d.size());
      d = d[0:cut-1];
    end
    return d;
  endfunction

  task automatic test_random();
    octet_q_t d;
    int       count;
    count = 0;
    while (bytes_sent < 1400) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // Noise: short runs of arbitrary bytes.
        d.delete();
        repeat ($urandom_range(1, 8)) d = {d, 8'($urandom)};
      end else begin
        d = build_datagram();
      end
      send_datagram(d);
      count++;
      if (count % 40 == 0) wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_long_datagram();
    wait_drained();
    test_random();
    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
